// ===== rtl/cobd_pkg.sv =====
// ----------------------------------------------------------------------------
// cobd_pkg: shared constants and helpers
// fixed formats, physical scale factors, cordic arctangent table, register codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cobd_pkg;

    // general data width, cordic widths
    localparam int DW           = 64;
    localparam int CW           = 34;
    localparam int ZW           = 33;
    localparam int CORDIC_STEPS = 28;
    localparam int MULQ_SHIFT   = 30;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0]          OBLIQUITY_TURN = 32'd279641635;

    // 1.0 in the q4.44 rate format
    localparam logic signed [DW-1:0] RATE_ONE = 64'sd17592186044416;

    // physical constants
    localparam logic [191:0] REARTH_M  = 192'd6378140;
    localparam logic [191:0] AU_M      = 192'd149597870660;
    localparam logic [191:0] LIGHT_MPS = 192'd299792458;
    localparam logic [191:0] DAYSID_NS = 192'd86164090530833;
    localparam logic [191:0] YRSID_NS  = 192'd31558149763545600;
    localparam logic [191:0] NS_PER_S  = 192'd1000000000;
    localparam logic [191:0] TWOPI_Q60 = 192'h6487ED5110B4611A;

    // derived scale factors, floors of exact ratios
    localparam logic [191:0] K_ROT_W = ((192'd256 * NS_PER_S) << 64) / DAYSID_NS;
    localparam logic [191:0] K_REV_W = ((192'd256 * NS_PER_S) << 64) / YRSID_NS;
    localparam logic [191:0] TROT_W  = (REARTH_M << 32) / LIGHT_MPS;
    localparam logic [191:0] TREV_W  = (AU_M << 32) / LIGHT_MPS;
    localparam logic [191:0] AROT_W  = (TWOPI_Q60 * REARTH_M) / LIGHT_MPS;
    localparam logic [191:0] VROT_W  = ({128'd0, AROT_W[63:0]} * NS_PER_S) / DAYSID_NS;
    localparam logic [191:0] AREV_W  = (TWOPI_Q60 * AU_M) / YRSID_NS;
    localparam logic [191:0] VREV_W  = ({128'd0, AREV_W[63:0]} * NS_PER_S) / LIGHT_MPS;

    localparam logic [DW-1:0] K_ROT = K_ROT_W[63:0];
    localparam logic [DW-1:0] K_REV = K_REV_W[63:0];
    localparam logic [DW-1:0] TROT  = TROT_W[63:0];
    localparam logic [DW-1:0] TREV  = TREV_W[63:0];
    localparam logic [DW-1:0] VROT  = VROT_W[63:0];
    localparam logic [DW-1:0] VREV  = VREV_W[63:0];

    // register map, index = paddr / 8
    typedef enum logic [2:0] {
        REG_SIDEREAL_MID = 3'd0,
        REG_AUTUMN_EQX   = 3'd1,
        REG_LATITUDE     = 3'd2,
        REG_LONGITUDE    = 3'd3,
        REG_DERIV_COUNT  = 3'd4
    } t_reg_idx;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            24: v = 33'sd41;
            25: v = 33'sd20;
            26: v = 33'sd10;
            27: v = 33'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

    // elaboration-time cordic for fixed angles, returns {cos, sin}
    function automatic logic [2*CW-1:0] cordic_const(input logic [31:0] ang);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        a    = longint'($signed(ang));
        flip = 1'b0;
        if (a > 64'sd1073741824) begin
            a    = a - 64'sd2147483648;
            flip = 1'b1;
        end else if (a < -64'sd1073741824) begin
            a    = a + 64'sd2147483648;
            flip = 1'b1;
        end
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = a;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_turn(i));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_turn(i));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        return {CW'(x), CW'(y)};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cobd_delay.sv =====
// ----------------------------------------------------------------------------
// cobd_delay: aligning shift line
// carries a value alongside the pipeline for a fixed number of stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobd_delay #(
    parameter int W     = 64,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_sh [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_d = r_sh[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/cobd_mul.sv =====
// ----------------------------------------------------------------------------
// cobd_mul: two-stage q30 product
// 64 by 34 bit signed product, floor-shifted by 30, kept to 64 bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobd_mul import cobd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [CW-1:0] i_b,
    output logic signed [DW-1:0] o_p
);

    // partial products of the upper and lower halves of a
    logic signed [DW/2+CW-1:0] r_ph;
    logic signed [DW/2+CW:0]   r_pl;
    logic signed [DW+CW-1:0]   full;

    assign full = ((DW+CW)'(r_ph) <<< (DW/2)) + (DW+CW)'(r_pl);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ph <= $signed(i_a[DW-1:DW/2]) * i_b;
            r_pl <= $signed({1'b0, i_a[DW/2-1:0]}) * i_b;
            o_p  <= full[DW+MULQ_SHIFT-1:MULQ_SHIFT];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cobd_cordic.sv =====
// ----------------------------------------------------------------------------
// cobd_cordic: unrolled rotation cordic
// one register stage per step, quadrant fold in front, sign restore behind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobd_cordic import cobd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_ang,
    output logic signed [CW-1:0] o_cos,
    output logic signed [CW-1:0] o_sin
);

    localparam logic signed [ZW-1:0] QUARTER = 33'sd1073741824;
    localparam logic signed [ZW-1:0] HALF    = 33'sd2147483648;

    logic signed [ZW-1:0] ang_s;
    logic signed [ZW-1:0] z_fold;
    logic                 flip;

    logic signed [CW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS];
    logic                 r_f [CORDIC_STEPS+1];

    // fold into plus or minus a quarter turn
    always_comb begin
        ang_s = $signed({i_ang[31], i_ang});
        priority if (ang_s > QUARTER) begin
            z_fold = ang_s - HALF;
            flip   = 1'b1;
        end else if (ang_s < -QUARTER) begin
            z_fold = ang_s + HALF;
            flip   = 1'b1;
        end else begin
            z_fold = ang_s;
            flip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= z_fold;
            r_f[0] <= flip;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    if (i < CORDIC_STEPS-1) r_z[i+1] <= r_z[i] - atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    if (i < CORDIC_STEPS-1) r_z[i+1] <= r_z[i] + atan_turn(i);
                end
                r_f[i+1] <= r_f[i];
            end
            o_cos <= r_f[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            o_sin <= r_f[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cobd_angle.sv =====
// ----------------------------------------------------------------------------
// cobd_angle: rotation and revolution phase
// time offset times turn rate, four partial products over four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobd_angle import cobd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_time,
    input  logic [DW-1:0] i_sidereal_mid,
    input  logic [DW-1:0] i_autumn_eqx,
    input  logic [31:0]   i_longitude,
    output logic [31:0]   o_rot,
    output logic [31:0]   o_rev
);

    logic [31:0] ang_w [2];

    for (genvar g = 0; g < 2; g++) begin : g_path
        localparam logic [DW-1:0] K = (g == 0) ? K_ROT : K_REV;

        logic [DW-1:0]       ref_t;
        logic [31:0]         off;
        logic signed [31:0]  r_dh;
        logic [31:0]         r_dl;
        logic signed [65:0]  r_hh;
        logic signed [65:0]  r_hl;
        logic [63:0]         r_lh;
        logic [63:0]         r_ll;
        logic signed [66:0]  r_mid;
        logic [63:0]         r_ll2;
        logic [31:0]         r_hh2;
        logic [95:0]         sum;
        logic [31:0]         r_ang;

        assign ref_t = (g == 0) ? i_sidereal_mid : i_autumn_eqx;
        assign off   = (g == 0) ? i_longitude : 32'd0;

        // bits 95..64 of the offset times the rate
        assign sum = {r_hh2, 64'd0} + {r_mid[63:0], 32'd0} + {32'd0, r_ll2};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_dh, r_dl} <= i_time - ref_t;
                r_hh  <= r_dh * $signed({1'b0, K[63:32]});
                r_hl  <= r_dh * $signed({1'b0, K[31:0]});
                r_lh  <= r_dl * K[63:32];
                r_ll  <= r_dl * K[31:0];
                r_mid <= 67'(r_hl) + $signed({3'd0, r_lh});
                r_ll2 <= r_ll;
                r_hh2 <= r_hh[31:0];
                r_ang <= sum[95:64] + off;
            end
        end

        assign ang_w[g] = r_ang;
    end

    assign o_rot = ang_w[0];
    assign o_rev = ang_w[1];

endmodule

`default_nettype wire

// ===== rtl/circular_orbit_barycentric_delay.sv =====
// ----------------------------------------------------------------------------
// circular_orbit_barycentric_delay: circular-orbit roemer delay and derivatives
// one request per cycle sustained while the output skid is empty
// depth set by the 28-step unrolled cordic and three layers of two-stage products
// a one-entry output skid takes the result that meets a stall, pipeline holds while full
// synchronous active-low reset clears valids, skid and config (count back to 3)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circular_orbit_barycentric_delay import cobd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    // input requests
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [63:0]   i_arrival_time,
    input  logic [31:0]          i_right_ascension,
    input  logic signed [31:0]   i_declination,
    // results
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [63:0]   o_barycentric_time,
    output logic signed [47:0]   o_rate_derivative,
    output logic signed [47:0]   o_ascension_derivative,
    output logic signed [47:0]   o_declination_derivative
);

    // stage plan, counted in registers after the input request
    localparam int ANG_LAT  = 4;
    localparam int COR_LAT  = CORDIC_STEPS + 2;
    localparam int MUL_LAT  = 2;
    localparam int ST_L1    = ANG_LAT + COR_LAT;   // cordic outputs
    localparam int ST_L2    = ST_L1 + MUL_LAT;     // first product layer
    localparam int ST_L3IN  = ST_L2 + MUL_LAT;     // second product layer
    localparam int ST_S2    = ST_L3IN + 1;         // position/velocity sums
    localparam int ST_L3    = ST_S2 + MUL_LAT;     // projection products
    localparam int ST_S3    = ST_L3 + 1;           // dot products
    localparam int LAT      = ST_S3 + 1;           // output register

    localparam int NCOR = 5;
    localparam int C_LAT = 0;
    localparam int C_ROT = 1;
    localparam int C_REV = 2;
    localparam int C_RA  = 3;
    localparam int C_DEC = 4;

    localparam int NL1 = 11;
    localparam int NL2 = 8;
    localparam int NL3 = 11;

    localparam logic [2*CW-1:0]      OBL_CS  = cordic_const(OBLIQUITY_TURN);
    localparam logic signed [CW-1:0] OBL_COS = OBL_CS[2*CW-1:CW];
    localparam logic signed [CW-1:0] OBL_SIN = OBL_CS[CW-1:0];

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [63:0] r_sidereal_mid;
    logic [63:0] r_autumn_eqx;
    logic [31:0] r_latitude;
    logic [31:0] r_longitude;
    logic [1:0]  r_dcount;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidereal_mid <= '0;
            r_autumn_eqx   <= '0;
            r_latitude     <= '0;
            r_longitude    <= '0;
            r_dcount       <= 2'd3;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_SIDEREAL_MID: r_sidereal_mid <= pwdata;
                REG_AUTUMN_EQX:   r_autumn_eqx   <= pwdata;
                REG_LATITUDE:     r_latitude     <= pwdata[31:0];
                REG_LONGITUDE:    r_longitude    <= pwdata[31:0];
                REG_DERIV_COUNT:  r_dcount       <= pwdata[1:0];
                default: ;  // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_SIDEREAL_MID: prdata = r_sidereal_mid;
            REG_AUTUMN_EQX:   prdata = r_autumn_eqx;
            REG_LATITUDE:     prdata = {32'd0, r_latitude};
            REG_LONGITUDE:    prdata = {32'd0, r_longitude};
            REG_DERIV_COUNT:  prdata = {62'd0, r_dcount};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // flow control: whole pipeline moves while the skid is empty
    // ------------------------------------------------------------------
    logic           en;
    logic           accept;
    logic [LAT-1:0] r_vld;
    logic           r_skid_v;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign accept  = i_valid & en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // phase angles, then sines and cosines of latitude, phases and source angles
    // ------------------------------------------------------------------
    logic [31:0] rot_ang;
    logic [31:0] rev_ang;
    logic [95:0] src_d;

    cobd_angle u_angle (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_time         (i_arrival_time),
        .i_sidereal_mid (r_sidereal_mid),
        .i_autumn_eqx   (r_autumn_eqx),
        .i_longitude    (r_longitude),
        .o_rot          (rot_ang),
        .o_rev          (rev_ang)
    );

    // source angles and latitude wait for the phase computation
    cobd_delay #(.W(96), .DEPTH(ANG_LAT)) u_src_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_latitude, i_declination, i_right_ascension}),
        .o_d   (src_d)
    );

    logic [31:0]          cor_ang [NCOR];
    logic signed [CW-1:0] cor_c   [NCOR];
    logic signed [CW-1:0] cor_s   [NCOR];

    assign cor_ang[C_LAT] = src_d[95:64];
    assign cor_ang[C_ROT] = rot_ang;
    assign cor_ang[C_REV] = rev_ang;
    assign cor_ang[C_RA]  = src_d[31:0];
    assign cor_ang[C_DEC] = src_d[63:32];

    for (genvar k = 0; k < NCOR; k++) begin : g_cor
        cobd_cordic u_cordic (
            .i_clk (i_clk),
            .i_en  (en),
            .i_ang (cor_ang[k]),
            .o_cos (cor_c[k]),
            .o_sin (cor_s[k])
        );
    end

    // ------------------------------------------------------------------
    // first product layer: radii, velocities, source direction
    // ------------------------------------------------------------------
    logic signed [DW-1:0] l1_a [NL1];
    logic signed [CW-1:0] l1_b [NL1];
    logic signed [DW-1:0] l1_p [NL1];

    assign l1_a[0]  = TROT;                 assign l1_b[0]  = cor_c[C_LAT];  // rcl
    assign l1_a[1]  = TREV;                 assign l1_b[1]  = cor_s[C_REV];  // rs
    assign l1_a[2]  = TREV;                 assign l1_b[2]  = cor_c[C_REV];
    assign l1_a[3]  = TROT;                 assign l1_b[3]  = cor_s[C_LAT];
    assign l1_a[4]  = DW'(cor_c[C_RA]);     assign l1_b[4]  = cor_c[C_DEC];  // n0
    assign l1_a[5]  = DW'(cor_s[C_RA]);     assign l1_b[5]  = cor_c[C_DEC];  // n1
    assign l1_a[6]  = VROT;                 assign l1_b[6]  = cor_c[C_LAT];  // vrc
    assign l1_a[7]  = VREV;                 assign l1_b[7]  = cor_s[C_REV];  // vs
    assign l1_a[8]  = VREV;                 assign l1_b[8]  = cor_c[C_REV];  // vc
    assign l1_a[9]  = DW'(cor_c[C_RA]);     assign l1_b[9]  = cor_s[C_DEC];  // m0
    assign l1_a[10] = DW'(cor_s[C_RA]);     assign l1_b[10] = cor_s[C_DEC];  // m1

    for (genvar k = 0; k < NL1; k++) begin : g_l1
        cobd_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (l1_a[k]),
            .i_b   (l1_b[k]),
            .o_p   (l1_p[k])
        );
    end

    // rotation cosines and sines wait for the radius products
    logic [2*CW-1:0] rot_cs_d;

    cobd_delay #(.W(2*CW), .DEPTH(ST_L2-ST_L1)) u_rot_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({cor_c[C_ROT], cor_s[C_ROT]}),
        .o_d   (rot_cs_d)
    );

    // ------------------------------------------------------------------
    // second product layer: rotate and tilt
    // ------------------------------------------------------------------
    logic signed [DW-1:0] l2_a [NL2];
    logic signed [CW-1:0] l2_b [NL2];
    logic signed [DW-1:0] l2_p [NL2];

    assign l2_a[0] = l1_p[0];  assign l2_b[0] = $signed(rot_cs_d[2*CW-1:CW]);
    assign l2_a[1] = l1_p[0];  assign l2_b[1] = $signed(rot_cs_d[CW-1:0]);
    assign l2_a[2] = l1_p[1];  assign l2_b[2] = OBL_COS;
    assign l2_a[3] = l1_p[1];  assign l2_b[3] = OBL_SIN;
    assign l2_a[4] = l1_p[6];  assign l2_b[4] = $signed(rot_cs_d[CW-1:0]);
    assign l2_a[5] = l1_p[6];  assign l2_b[5] = $signed(rot_cs_d[2*CW-1:CW]);
    assign l2_a[6] = l1_p[8];  assign l2_b[6] = OBL_COS;
    assign l2_a[7] = l1_p[8];  assign l2_b[7] = OBL_SIN;

    for (genvar k = 0; k < NL2; k++) begin : g_l2
        cobd_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (l2_a[k]),
            .i_b   (l2_b[k]),
            .o_p   (l2_p[k])
        );
    end

    // first-layer terms and declination cosines and sines that skip the second layer
    logic [3*DW-1:0] pass_d;
    logic [4*CW-1:0] dir_d;
    logic [2*CW-1:0] dec_d;

    cobd_delay #(.W(3*DW), .DEPTH(ST_L3IN-ST_L2)) u_pass_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({l1_p[2], l1_p[3], l1_p[7]}),
        .o_d   (pass_d)
    );

    cobd_delay #(.W(4*CW), .DEPTH(ST_L3IN-ST_L2)) u_dir_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({l1_p[4][CW-1:0], l1_p[5][CW-1:0], l1_p[9][CW-1:0], l1_p[10][CW-1:0]}),
        .o_d   (dir_d)
    );

    cobd_delay #(.W(2*CW), .DEPTH(ST_L3IN-ST_L1)) u_dec_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({cor_c[C_DEC], cor_s[C_DEC]}),
        .o_d   (dec_d)
    );

    // ------------------------------------------------------------------
    // position (q32 light-s) and velocity (q60) sums
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_x0, r_x1, r_x2;
    logic signed [DW-1:0] r_v0, r_v1, r_v2;
    logic signed [CW-1:0] r_n0, r_n1, r_nn1, r_n2, r_m0, r_m1, r_cd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0  <= l2_p[0] + $signed(pass_d[3*DW-1:2*DW]);
            r_x1  <= l2_p[1] + l2_p[2];
            r_x2  <= $signed(pass_d[2*DW-1:DW]) + l2_p[3];
            r_v0  <= -l2_p[4] - $signed(pass_d[DW-1:0]);
            r_v1  <= l2_p[5] + l2_p[6];
            r_v2  <= l2_p[7];
            r_n0  <= $signed(dir_d[4*CW-1:3*CW]);
            r_n1  <= $signed(dir_d[3*CW-1:2*CW]);
            r_nn1 <= -$signed(dir_d[3*CW-1:2*CW]);
            r_m0  <= $signed(dir_d[2*CW-1:CW]);
            r_m1  <= $signed(dir_d[CW-1:0]);
            r_n2  <= $signed(dec_d[CW-1:0]);
            r_cd  <= $signed(dec_d[2*CW-1:CW]);
        end
    end

    // ------------------------------------------------------------------
    // third product layer: projections onto the source direction
    // ------------------------------------------------------------------
    logic signed [DW-1:0] l3_a [NL3];
    logic signed [CW-1:0] l3_b [NL3];
    logic signed [DW-1:0] l3_p [NL3];

    assign l3_a[0]  = r_x0;  assign l3_b[0]  = r_n0;
    assign l3_a[1]  = r_x1;  assign l3_b[1]  = r_n1;
    assign l3_a[2]  = r_x2;  assign l3_b[2]  = r_n2;
    assign l3_a[3]  = r_v0;  assign l3_b[3]  = r_n0;
    assign l3_a[4]  = r_v1;  assign l3_b[4]  = r_n1;
    assign l3_a[5]  = r_v2;  assign l3_b[5]  = r_n2;
    assign l3_a[6]  = r_x0;  assign l3_b[6]  = r_nn1;
    assign l3_a[7]  = r_x1;  assign l3_b[7]  = r_n0;
    assign l3_a[8]  = r_x0;  assign l3_b[8]  = r_m0;
    assign l3_a[9]  = r_x1;  assign l3_b[9]  = r_m1;
    assign l3_a[10] = r_x2;  assign l3_b[10] = r_cd;

    for (genvar k = 0; k < NL3; k++) begin : g_l3
        cobd_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (l3_a[k]),
            .i_b   (l3_b[k]),
            .o_p   (l3_p[k])
        );
    end

    // dot products
    logic signed [DW-1:0] r_d, r_dv, r_g2, r_g3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d  <= l3_p[0] + l3_p[1] + l3_p[2];
            r_dv <= l3_p[3] + l3_p[4] + l3_p[5];
            r_g2 <= l3_p[6] + l3_p[7];
            r_g3 <= -l3_p[8] - l3_p[9] + l3_p[10];
        end
    end

    // arrival time rides along to the final add
    logic [DW-1:0] t_d;

    cobd_delay #(.W(DW), .DEPTH(ST_S3)) u_time_dly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (i_arrival_time),
        .o_d   (t_d)
    );

    // ------------------------------------------------------------------
    // output register, derivative gating by configured count
    // ------------------------------------------------------------------
    logic signed [63:0] r_out_bt;
    logic signed [47:0] r_out_rd, r_out_ad, r_out_dd;
    logic signed [DW-1:0] rate_full;

    assign rate_full = RATE_ONE + (r_dv >>> 16);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_bt <= $signed(t_d) + (r_d >>> 8);
            r_out_rd <= (r_dcount >= 2'd1) ? rate_full[47:0] : '0;
            r_out_ad <= (r_dcount >= 2'd2) ? r_g2[47:0] : '0;
            r_out_dd <= (r_dcount >= 2'd3) ? r_g3[47:0] : '0;
        end
    end

    // ------------------------------------------------------------------
    // skid: catches the tail result when the consumer stalls
    // ------------------------------------------------------------------
    logic signed [63:0] r_sk_bt;
    logic signed [47:0] r_sk_rd, r_sk_ad, r_sk_dd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (!i_stall) r_skid_v <= 1'b0;
        end else if (r_vld[LAT-1] && i_stall) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            r_sk_bt <= r_out_bt;
            r_sk_rd <= r_out_rd;
            r_sk_ad <= r_out_ad;
            r_sk_dd <= r_out_dd;
        end
    end

    assign o_valid                  = r_skid_v | r_vld[LAT-1];
    assign o_barycentric_time       = r_skid_v ? r_sk_bt : r_out_bt;
    assign o_rate_derivative        = r_skid_v ? r_sk_rd : r_out_rd;
    assign o_ascension_derivative   = r_skid_v ? r_sk_ad : r_out_ad;
    assign o_declination_derivative = r_skid_v ? r_sk_dd : r_out_dd;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_free_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_vld[LAT-1] && i_stall))
        else $error("skid filled without a stalled result");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> !r_skid_v)
        else $error("skid not released after its result was taken");

endmodule

`default_nettype wire

// ===== test/circular_orbit_barycentric_delay_test.sv =====
// ----------------------------------------------------------------------------
// circular_orbit_barycentric_delay_test: self-checking bench for the roemer delay block
// drives arrival times and sky positions through several register settings,
// predicts the barycentred time and its derivatives from a cycle-free model
// of the circular orbit and cordic, and compares every result in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_orbit_barycentric_delay_test;
    import cobd_pkg::*;

    // bench's own scale factors, floors of exact ratios
    localparam logic [191:0] C_NS     = 192'd1000000000;
    localparam logic [191:0] C_LIGHT  = 192'd299792458;
    localparam logic [191:0] C_DAY    = 192'd86164090530833;
    localparam logic [191:0] C_YEAR   = 192'd31558149763545600;
    localparam logic [191:0] C_REARTH = 192'd6378140;
    localparam logic [191:0] C_AU     = 192'd149597870660;
    localparam logic [191:0] C_TWOPI  = 192'h6487ED5110B4611A;
    localparam logic [191:0] SPIN_W   = ((192'd256 * C_NS) << 64) / C_DAY;
    localparam logic [191:0] ORBIT_W  = ((192'd256 * C_NS) << 64) / C_YEAR;
    localparam logic [191:0] RADIUS_W = (C_REARTH << 32) / C_LIGHT;
    localparam logic [191:0] AU_LS_W  = (C_AU << 32) / C_LIGHT;
    localparam logic [191:0] SPINA_W  = (C_TWOPI * C_REARTH) / C_LIGHT;
    localparam logic [191:0] SPINV_W  = ({128'd0, SPINA_W[63:0]} * C_NS) / C_DAY;
    localparam logic [191:0] ORBA_W   = (C_TWOPI * C_AU) / C_YEAR;
    localparam logic [191:0] ORBV_W   = ({128'd0, ORBA_W[63:0]} * C_NS) / C_LIGHT;
    localparam longint SPIN_K    = SPIN_W[63:0];
    localparam longint ORBIT_K   = ORBIT_W[63:0];
    localparam longint RADIUS_LS = RADIUS_W[63:0];
    localparam longint AU_LS     = AU_LS_W[63:0];
    localparam longint SPIN_VEL  = SPINV_W[63:0];
    localparam longint ORBIT_VEL = ORBV_W[63:0];
    localparam longint GAIN_Q30  = 652032874;
    localparam logic [31:0] TILT_TURN = 32'd279641635;
    localparam longint ATAN_TURN [0:27] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
        5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

    localparam int PIPE_DRAIN = 60;
    localparam int CYCLE_LIMIT = 250000;
    localparam int RANDOM_PER_PHASE = 113;
    localparam int NUM_PHASES = 6;

    typedef struct packed {
        logic [63:0] bary;
        logic [47:0] rate;
        logic [47:0] d_ra;
        logic [47:0] d_dec;
    } t_delay;

    typedef struct {
        logic [63:0] t;
        logic [31:0] ra;
        logic [31:0] dec;
    } t_sky_req;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic signed [63:0] i_arrival_time;
    logic [31:0] i_right_ascension;
    logic signed [31:0] i_declination;
    logic        o_valid;
    logic        i_stall;
    logic signed [63:0] o_barycentric_time;
    logic signed [47:0] o_rate_derivative;
    logic signed [47:0] o_ascension_derivative;
    logic signed [47:0] o_declination_derivative;

    circular_orbit_barycentric_delay u_top (.*);

    // shadow copy of the register file
    logic [63:0] midnight_ref, equinox_ref;
    logic [31:0] site_lat, site_lon;
    logic [1:0]  deriv_cnt;

    t_delay pending_delays[$];
    int     error_count;
    int     cycle_count;
    bit     hold_request;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // floor(a*b / 2^30) kept to 64 bits
    function automatic longint fmul(input longint a, input longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return p[93:30];
    endfunction

    // upper half of the signed 128-bit product
    function automatic longint fmul_hi(input longint a, input longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return p[127:64];
    endfunction

    // 28-step rotation, cos and sin in q30, angle in turn units
    task automatic turn_sincos(input logic [31:0] ang, output longint c, output longint s);
        longint a, x, y, z, nx;
        bit     flip;
        a = longint'($signed(ang));
        flip = 1'b0;
        if (a > 64'sd1073741824) begin
            a = a - 64'sd2147483648;
            flip = 1'b1;
        end else if (a < -64'sd1073741824) begin
            a = a + 64'sd2147483648;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = a;
        for (int i = 0; i < 28; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TURN[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_delay(input t_sky_req rq, output t_delay res);
        longint clat, slat, crot, srot, crev, srev, ci, si, cra, sra, cdec, sdec;
        longint rcl, rs, x0, x1, x2, n0, n1, n2, d;
        longint vrc, vs, vc, v0, v1, v2, dv, m0, m1, tmp;
        logic [31:0] rot_ang, rev_ang;
        rot_ang = 32'(fmul_hi(longint'(rq.t - midnight_ref), SPIN_K)) + site_lon;
        rev_ang = 32'(fmul_hi(longint'(rq.t - equinox_ref), ORBIT_K));
        turn_sincos(site_lat, clat, slat);
        turn_sincos(rot_ang, crot, srot);
        turn_sincos(rev_ang, crev, srev);
        turn_sincos(TILT_TURN, ci, si);
        turn_sincos(rq.ra, cra, sra);
        turn_sincos(rq.dec, cdec, sdec);
        // detector position, q32 light-seconds
        rcl = fmul(RADIUS_LS, clat);
        rs  = fmul(AU_LS, srev);
        x0  = fmul(rcl, crot) + fmul(AU_LS, crev);
        x1  = fmul(rcl, srot) + fmul(rs, ci);
        x2  = fmul(RADIUS_LS, slat) + fmul(rs, si);
        // unit vector toward the source
        n0 = fmul(cra, cdec);
        n1 = fmul(sra, cdec);
        n2 = sdec;
        d = fmul(x0, n0) + fmul(x1, n1) + fmul(x2, n2);
        res.bary = rq.t + 64'(d >>> 8);
        res.rate = '0;
        res.d_ra = '0;
        res.d_dec = '0;
        if (deriv_cnt >= 1) begin
            vrc = fmul(SPIN_VEL, clat);
            vs  = fmul(ORBIT_VEL, srev);
            vc  = fmul(ORBIT_VEL, crev);
            v0  = -fmul(vrc, srot) - vs;
            v1  = fmul(vrc, crot) + fmul(vc, ci);
            v2  = fmul(vc, si);
            dv  = fmul(v0, n0) + fmul(v1, n1) + fmul(v2, n2);
            tmp = (64'sd1 <<< 44) + (dv >>> 16);
            res.rate = tmp[47:0];
        end
        if (deriv_cnt >= 2) begin
            tmp = fmul(x0, -n1) + fmul(x1, n0);
            res.d_ra = tmp[47:0];
        end
        if (deriv_cnt >= 3) begin
            m0 = fmul(cra, sdec);
            m1 = fmul(sra, sdec);
            tmp = -fmul(x0, m0) - fmul(x1, m1) + fmul(x2, cdec);
            res.d_dec = tmp[47:0];
        end
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // accepted requests turn into expectations at the edge they are taken
    always @(posedge i_clk) begin
        t_sky_req rq;
        t_delay   exp_d;
        if (i_rst_n && i_valid && !o_stall) begin
            rq.t = i_arrival_time;
            rq.ra = i_right_ascension;
            rq.dec = i_declination;
            predict_delay(rq, exp_d);
            pending_delays.push_back(exp_d);
        end
    end

    // accepted results compared with the oldest expectation
    always @(posedge i_clk) begin
        t_delay want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_delays.size() == 0) begin
                report_mismatch("unexpected result", o_barycentric_time, '0);
            end else begin
                want = pending_delays.pop_front();
                if (o_barycentric_time !== want.bary)
                    report_mismatch("barycentric_time", o_barycentric_time, want.bary);
                if (o_rate_derivative !== want.rate)
                    report_mismatch("rate_derivative", 64'(o_rate_derivative), 64'(want.rate));
                if (o_ascension_derivative !== want.d_ra)
                    report_mismatch("ascension_derivative", 64'(o_ascension_derivative),
                                    64'(want.d_ra));
                if (o_declination_derivative !== want.d_dec)
                    report_mismatch("declination_derivative", 64'(o_declination_derivative),
                                    64'(want.d_dec));
            end
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // idle pattern shared by both sides: mostly a uniformly drawn gap, sometimes a gapless run
    // ------------------------------------------------------------------
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // result side: random stalls, plus one long hold-off to back the pipe up
    initial begin
        int run_left;
        int gap;
        run_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                hold_request = 1'b0;
            end
            gap = draw_gap(run_left);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_stall <= 1'b0;
            // hold low until a result is taken
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // apb write: setup cycle then access cycle, called at a falling edge
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIDEREAL_MID: midnight_ref = val;
            REG_AUTUMN_EQX:   equinox_ref = val;
            REG_LATITUDE:     site_lat = val[31:0];
            REG_LONGITUDE:    site_lon = val[31:0];
            REG_DERIV_COUNT:  deriv_cnt = val[1:0];
            default: ;
        endcase
    endtask

    int send_run;

    // offers one request and returns at the falling edge after it is taken
    task automatic send_request(input t_sky_req rq);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_arrival_time    <= rq.t;
        i_right_ascension <= rq.ra;
        i_declination     <= rq.dec;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // waits until every result is back, then lets the pipe drain
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_delays.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    function automatic t_sky_req random_request();
        t_sky_req rq;
        rq.t  = {$urandom, $urandom};
        // mostly plausible epochs, sometimes the whole signed range
        if ($urandom_range(0, 3) != 0)
            rq.t = $signed(rq.t) >>> $urandom_range(0, 40);
        rq.ra = $urandom;
        if ($urandom_range(0, 3) != 0)
            rq.dec = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        else
            rq.dec = $urandom;
        return rq;
    endfunction

    // directed requests: field extremes and the quarter-turn edges
    t_sky_req edge_rows [0:19] = '{
        '{64'h0000_0000_0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{64'h8000_0000_0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000},
        '{64'h0000_0000_0000_0001, 32'h4000_0000, 32'h4000_0000},
        '{64'h0000_0000_0100_0000, 32'h8000_0000, 32'hC000_0000},
        '{64'h0000_0151_8000_0000, 32'hC000_0000, 32'h3FFF_FFFF},
        '{64'h0001_E133_8000_0000, 32'h2000_0000, 32'hC000_0001},
        '{64'h0000_0000_0000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
        '{64'h0000_0000_0000_0000, 32'h0000_0000, 32'h8000_0000},
        '{64'h0000_0000_0000_0000, 32'h0000_0000, 32'h4000_0001},
        '{64'h0000_0000_0000_0000, 32'h7FFF_FFFF, 32'hBFFF_FFFF},
        '{64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000},
        '{64'h8000_0000_0000_0000, 32'h8000_0000, 32'hC000_0000},
        '{64'h5555_5555_5555_5555, 32'h5555_5555, 32'h1555_5555},
        '{64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 32'hEAAA_AAAA},
        '{64'h0000_0000_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{64'hFFFF_FF00_0000_0000, 32'h0000_0001, 32'h0000_0001},
        '{64'h0000_00FF_FFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF},
        '{64'h1234_5678_9ABC_DEF0, 32'h0FED_CBA9, 32'h2468_ACE0}};

    initial begin
        t_sky_req rq;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_arrival_time = '0;
        i_right_ascension = '0;
        i_declination = '0;
        midnight_ref = '0;
        equinox_ref = '0;
        site_lat = '0;
        site_lon = '0;
        deriv_cnt = 2'd3;
        error_count = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        send_run = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of the registers, directed rows first
        foreach (edge_rows[i]) send_request(edge_rows[i]);
        for (int n = 0; n < RANDOM_PER_PHASE / 2; n++) send_request(random_request());

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                1: begin
                    reg_write(REG_SIDEREAL_MID, {$urandom, $urandom});
                    reg_write(REG_AUTUMN_EQX, {$urandom, $urandom});
                    reg_write(REG_LATITUDE, 64'h4000_0000);
                    reg_write(REG_LONGITUDE, 64'h7FFF_FFFF);
                    reg_write(REG_DERIV_COUNT, 64'd0);
                end
                2: begin
                    reg_write(REG_SIDEREAL_MID, 64'h7FFF_FFFF_FFFF_FFFF);
                    reg_write(REG_AUTUMN_EQX, 64'h8000_0000_0000_0000);
                    reg_write(REG_LATITUDE, 64'hFFFF_FFFF_C000_0000);
                    reg_write(REG_LONGITUDE, 64'h8000_0000);
                    reg_write(REG_DERIV_COUNT, 64'd1);
                end
                3: begin
                    // latitude past the pole is used as the angle it encodes
                    reg_write(REG_LATITUDE, 64'h7FFF_FFFF);
                    reg_write(REG_LONGITUDE, $urandom);
                    reg_write(REG_DERIV_COUNT, 64'd2);
                    // unused slots must leave the registers alone
                    reg_write(3'd5, {$urandom, $urandom});
                    reg_write(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
                    hold_request = 1'b1;
                end
                4: begin
                    reg_write(REG_SIDEREAL_MID, 64'h8000_0000_0000_0000);
                    reg_write(REG_AUTUMN_EQX, 64'h7FFF_FFFF_FFFF_FFFF);
                    reg_write(REG_LATITUDE, 64'h8000_0000);
                    reg_write(REG_DERIV_COUNT, 64'd3);
                end
                default: begin
                    reg_write(REG_SIDEREAL_MID, {$urandom, $urandom});
                    reg_write(REG_AUTUMN_EQX, {$urandom, $urandom});
                    reg_write(REG_LATITUDE, $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
                    reg_write(REG_LONGITUDE, $urandom);
                    reg_write(REG_DERIV_COUNT, $urandom_range(0, 3));
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE + 10 * (ph == 5); n++) begin
                rq = random_request();
                send_request(rq);
            end
        end

        i_valid <= 1'b0;
        while (pending_delays.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
